// File: src/crcd_pkg.sv
// Shared types and constants for the control report change decoder.
`default_nettype none
package crcd_pkg;

   localparam int BUTTON_BITS_DEF  = 32;
   localparam int MAX_ENCODERS     = 8;
   localparam int NUM_ENCODERS_DEF = MAX_ENCODERS;

   localparam int MAP_W         = 32;
   localparam int MAIN_W        = 8;
   localparam int ENC_W         = 16;
   localparam int REQ_TDATA_W   = 168;
   localparam int RSP_TDATA_W   = 8;
   localparam int EVENT_BUTTONS = 24;
   localparam int SHIFT_BIT     = 16;

   // button slots first, then main encoder, then encoders 1..8
   localparam int NUM_SLOTS  = EVENT_BUTTONS + MAX_ENCODERS + 1;
   localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
   localparam int EV_IDX_W   = 5;

   localparam logic [MAIN_W-1:0] MAIN_WRAP_TOP = 8'h0f;
   localparam logic [MAIN_W-1:0] MAIN_WRAP_BOT = 8'h00;
   localparam logic [3:0]        ENC_WRAP_TOP  = 4'd3;
   localparam logic [3:0]        ENC_WRAP_BOT  = 4'd0;

   localparam logic KIND_BUTTON  = 1'b0;
   localparam logic KIND_ENCODER = 1'b1;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] valid;
      logic [NUM_SLOTS-1:0] up;
      logic                 shift;
   } crcd_load_type;

endpackage
`default_nettype wire

// File: src/crcd_enc_lane.sv
// One encoder lane: keeps the last position and judges the direction of a change.
`default_nettype none
module crcd_enc_lane
   import crcd_pkg::*;
#(
   parameter bit IS_MAIN = 1'b0,
   parameter int W       = ENC_W
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire logic [W-1:0] cur,
   output logic              changed,
   output logic              up
);

   logic [W-1:0] prev_ff, prev_in;
   logic [15:0]  p16, c16;
   logic         wrap_up, wrap_down;

   assign p16 = 16'(prev_ff);
   assign c16 = 16'(cur);

   always_comb begin
      if (IS_MAIN) begin
         wrap_up   = (p16[7:0] == MAIN_WRAP_TOP) && (c16 == 16'(MAIN_WRAP_BOT));
         wrap_down = (p16[7:0] == MAIN_WRAP_BOT) && (c16 == 16'(MAIN_WRAP_TOP));
      end else begin
         // old nibble of the high byte against the whole new high byte
         wrap_up   = (p16[11:8] == ENC_WRAP_TOP) && (c16[15:8] == 8'(ENC_WRAP_BOT));
         wrap_down = (p16[11:8] == ENC_WRAP_BOT) && (c16[15:8] == 8'(ENC_WRAP_TOP));
      end
   end

   assign changed = (cur != prev_ff);
   assign up      = ((p16 < c16) || wrap_up) && !wrap_down;
   assign prev_in = load ? cur : prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule
`default_nettype wire

// File: src/crcd_merge.sv
// Merge stage: emits the pending events of all lanes lowest slot first.
`default_nettype none
module crcd_merge
   import crcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load_valid,
   input  wire crcd_load_type          load,
   output logic                        busy,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   logic [NUM_SLOTS-1:0]  pend_ff, pend_in;
   logic [NUM_SLOTS-1:0]  up_ff, up_in;
   logic                  shift_ff, shift_in;
   logic                  vld_ff, vld_in;
   logic                  kind_ff, kind_in;
   logic [EV_IDX_W-1:0]   idx_ff, idx_in;
   logic                  dir_ff, dir_in;
   logic                  sh_ff, sh_in;
   logic                  last_ff, last_in;

   logic [NUM_SLOTS-1:0]  lowest;
   logic [SLOT_IDX_W-1:0] slot;
   logic                  advance;

   assign busy    = |pend_ff;
   assign advance = busy && (!vld_ff || rsp_tready);
   assign lowest  = pend_ff & (~pend_ff + NUM_SLOTS'(1));

   always_comb begin
      slot = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (lowest[i]) begin
            slot = slot | SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      pend_in  = pend_ff;
      up_in    = up_ff;
      shift_in = shift_ff;
      vld_in   = vld_ff && !rsp_tready;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      dir_in   = dir_ff;
      sh_in    = sh_ff;
      last_in  = last_ff;
      if (load_valid) begin
         pend_in  = load.valid;
         up_in    = load.up;
         shift_in = load.shift;
      end else if (advance) begin
         pend_in = pend_ff & ~lowest;
      end
      if (advance) begin
         vld_in = 1'b1;
         if (slot < SLOT_IDX_W'(EVENT_BUTTONS)) begin
            kind_in = KIND_BUTTON;
            idx_in  = EV_IDX_W'(slot);
         end else begin
            kind_in = KIND_ENCODER;
            idx_in  = EV_IDX_W'(slot - SLOT_IDX_W'(EVENT_BUTTONS));
         end
         dir_in  = |(lowest & up_ff);
         sh_in   = shift_ff;
         last_in = ((pend_ff & ~lowest) == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         vld_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         vld_ff  <= vld_in;
      end
      up_ff    <= up_in;
      shift_ff <= shift_in;
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      dir_ff   <= dir_in;
      sh_ff    <= sh_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({sh_ff, dir_ff, idx_ff});

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      load_valid |-> !busy) else $error("report loaded while events pending");

   a_one_per_step: assert property (@(posedge clock) disable iff (reset)
      advance |=> $countones(pend_ff) == $past($countones(pend_ff)) - 1)
      else $error("pending set did not lose exactly one event");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && last_in) |=> !busy) else $error("last event with events left");

   a_lowest_single: assert property (@(posedge clock) disable iff (reset)
      $onehot0(lowest)) else $error("slot pick not one-hot");

endmodule
`default_nettype wire

// File: src/control_report_change_decoder_top.sv
// Top level of the control report change decoder: button and encoder lanes feeding the merge.
// A report is taken when no events of the previous one are pending; the lanes compare it
// with the kept state in the accept cycle and the merge stage holds the resulting events.
// Events pass from the pending set into the output register, one per cycle while not stalled.
// A report gives at most 32 events.
// A report with no change gives no event.
// Reset clears the kept buttons and encoder positions and drops any pending events.
`default_nettype none
module control_report_change_decoder_top
   import crcd_pkg::*;
#(
   parameter int BUTTON_BITS  = BUTTON_BITS_DEF,
   parameter int NUM_ENCODERS = NUM_ENCODERS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // button_bits[31:0], main_encoder[39:32], touch_encoder_1..8 16 bits each from bit 40
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // event_index[4:0], pressed_or_up[5], shift_held[6], zero[7]
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // event_kind[0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   logic                   accept;
   logic                   busy;
   logic [BUTTON_BITS-1:0] map_w;
   logic [BUTTON_BITS-1:0] prev_buttons_ff, prev_buttons_in;
   crcd_load_type          load;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;

   for (genvar g = 0; g < BUTTON_BITS; g++) begin : g_map
      if (g < MAP_W) begin : g_in
         assign map_w[g] = req_tdata[g];
      end else begin : g_zero
         assign map_w[g] = 1'b0;
      end
   end

   assign prev_buttons_in = accept ? map_w : prev_buttons_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_buttons_ff <= '0;
      end else begin
         prev_buttons_ff <= prev_buttons_in;
      end
   end

   // button lanes; shift and unused bits never raise an event
   for (genvar b = 0; b < EVENT_BUTTONS; b++) begin : g_btn
      if (b < BUTTON_BITS && b != SHIFT_BIT) begin : g_on
         assign load.valid[b] = map_w[b] ^ prev_buttons_ff[b];
         assign load.up[b]    = map_w[b];
      end else begin : g_off
         assign load.valid[b] = 1'b0;
         assign load.up[b]    = 1'b0;
      end
   end

   crcd_enc_lane #(
      .IS_MAIN (1'b1),
      .W       (MAIN_W)
   ) u_main_lane (
      .clock   (clock),
      .reset   (reset),
      .load    (accept),
      .cur     (req_tdata[MAP_W +: MAIN_W]),
      .changed (load.valid[EVENT_BUTTONS]),
      .up      (load.up[EVENT_BUTTONS])
   );

   for (genvar e = 0; e < MAX_ENCODERS; e++) begin : g_enc
      if (e < NUM_ENCODERS) begin : g_on
         crcd_enc_lane #(
            .IS_MAIN (1'b0),
            .W       (ENC_W)
         ) u_lane (
            .clock   (clock),
            .reset   (reset),
            .load    (accept),
            .cur     (req_tdata[MAP_W + MAIN_W + e*ENC_W +: ENC_W]),
            .changed (load.valid[EVENT_BUTTONS + 1 + e]),
            .up      (load.up[EVENT_BUTTONS + 1 + e])
         );
      end else begin : g_off
         assign load.valid[EVENT_BUTTONS + 1 + e] = 1'b0;
         assign load.up[EVENT_BUTTONS + 1 + e]    = 1'b0;
      end
   end

   assign load.shift = req_tdata[SHIFT_BIT];

   crcd_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (accept),
      .load       (load),
      .busy       (busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
